// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the label select and relabel block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RLSR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define RLSR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/rlsr_pkg.sv =====
// ---------------------------------------------------------------------------
// rlsr_pkg
// Types, sizes, command codes and helpers of the region label select block.
// ---------------------------------------------------------------------------
package rlsr_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_SEL     = 16;
    localparam int LABEL_BITS  = 16;

    localparam int PIXELS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_BITS    = $clog2(PIXELS);
    localparam int NPIX_BITS   = $clog2(PIXELS + 1);
    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CNT_BITS    = $clog2(MAX_SEL + 1);

    localparam int DIM_BITS    = 9;
    localparam int IDX_BITS    = 16;
    localparam int LVAL_BITS   = 16;
    localparam int COORD_BITS  = 10;
    localparam int SCOORD_BITS = COORD_BITS + 1;
    localparam int FILL_BITS   = 8;
    localparam int CMD_BITS    = 2;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [PIX_BITS-1:0]   t_pix;
    typedef logic [NPIX_BITS-1:0]  t_npix;
    typedef logic [LABEL_BITS-1:0] t_label;
    typedef logic [DIM_BITS-1:0]   t_dim;
    typedef logic [FILL_BITS-1:0]  t_fill;
    typedef logic [CMD_BITS-1:0]   t_cmd;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_cmd CMD_LOAD   = 2'd0;
    localparam t_cmd CMD_SELECT = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;
    localparam t_cmd CMD_READ   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'b1;

    localparam t_dim DIM_RESET = DIM_BITS'(256);

    typedef struct packed {
        logic   work_we;
        logic   orig_we;
        t_pix   waddr;
        t_label wdata;
        t_pix   work_raddr;
        t_pix   orig_raddr;
    } t_lbl_req;

    typedef struct packed {
        logic  we;
        t_pix  waddr;
        t_fill wdata;
        t_pix  raddr;
    } t_mask_req;

    typedef struct packed {
        logic clr;
        logic ins;
    } t_set_ctl;

    typedef struct packed {
        logic hit;
        logic ovf;
        logic count_nz;
    } t_set_stat;

    // Zero counts as one; larger values saturate at the maximum.
    function automatic t_dim clamp_dim(input t_dim v, input t_dim vmax);
        t_dim res;
        if (v == '0) begin
            res = t_dim'(1);
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== src/rlsr_if.sv =====
// ---------------------------------------------------------------------------
// rlsr_if
// Channel interfaces: command items, result items and configuration writes.
// ---------------------------------------------------------------------------
interface rlsr_item_if;
    logic                             valid;
    logic                             ready;
    logic [rlsr_pkg::CMD_BITS-1:0]    command;
    logic [rlsr_pkg::IDX_BITS-1:0]    pixel_index;
    logic [rlsr_pkg::LVAL_BITS-1:0]   label_value;
    logic signed [rlsr_pkg::COORD_BITS-1:0] first_column;
    logic signed [rlsr_pkg::COORD_BITS-1:0] first_row;
    logic signed [rlsr_pkg::COORD_BITS-1:0] last_column;
    logic signed [rlsr_pkg::COORD_BITS-1:0] last_row;
    logic [rlsr_pkg::FILL_BITS-1:0]   fill_value;

    modport source (
        output valid, command, pixel_index, label_value,
        output first_column, first_row, last_column, last_row, fill_value,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_index, label_value,
        input  first_column, first_row, last_column, last_row, fill_value,
        output ready
    );
endinterface

interface rlsr_result_if;
    logic                           valid;
    logic                           ready;
    logic [rlsr_pkg::FILL_BITS-1:0] mask_value;
    logic                           found;
    logic                           overflow;

    modport source (output valid, mask_value, found, overflow, input ready);
    modport sink   (input valid, mask_value, found, overflow, output ready);
endinterface

interface rlsr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rlsr_pkg::CFG_IDX_BITS-1:0] index;
    logic [rlsr_pkg::DIM_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rlsr_label_mem.sv =====
// ---------------------------------------------------------------------------
// rlsr_label_mem
// Working and original label stores, one write and one read port each.
// ---------------------------------------------------------------------------
module rlsr_label_mem (
    input  logic               i_clk,
    input  rlsr_pkg::t_lbl_req i_req,
    output rlsr_pkg::t_label   o_work_rdata,
    output rlsr_pkg::t_label   o_orig_rdata
);
    import rlsr_pkg::*;

    t_label r_work_mem [PIXELS];
    t_label r_orig_mem [PIXELS];
    t_label r_work_rd;
    t_label r_orig_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.work_we) begin
            r_work_mem[i_req.waddr] <= i_req.wdata;
        end
        r_work_rd <= r_work_mem[i_req.work_raddr];
    end

    // A load writes the same word into both stores.
    always_ff @(posedge i_clk) begin
        if (i_req.orig_we) begin
            r_orig_mem[i_req.waddr] <= i_req.wdata;
        end
        r_orig_rd <= r_orig_mem[i_req.orig_raddr];
    end

    assign o_work_rdata = r_work_rd;
    assign o_orig_rdata = r_orig_rd;

endmodule

// ===== src/rlsr_mask_mem.sv =====
// ---------------------------------------------------------------------------
// rlsr_mask_mem
// Mask store, one write and one registered read port.
// ---------------------------------------------------------------------------
module rlsr_mask_mem (
    input  logic                i_clk,
    input  rlsr_pkg::t_mask_req i_req,
    output rlsr_pkg::t_fill     o_rdata
);
    import rlsr_pkg::*;

    t_fill r_mem [PIXELS];
    t_fill r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rd;

endmodule

// ===== src/rlsr_label_set.sv =====
// ---------------------------------------------------------------------------
// rlsr_label_set
// Bounded set of selected labels with parallel membership test.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rlsr_label_set (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlsr_pkg::t_set_ctl  i_ctl,
    input  rlsr_pkg::t_label    i_label,
    output rlsr_pkg::t_set_stat o_stat
);
    import rlsr_pkg::*;

    t_label r_set [MAX_SEL];
    t_cnt   r_count;
    t_cnt   n_count;
    logic   r_ovf;
    logic   n_ovf;
    logic   hit;
    logic   ins_new;

    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < MAX_SEL; k++) begin
            if ((t_cnt'(k) < r_count) && (r_set[k] == i_label)) begin
                hit = 1'b1;
            end
        end
    end

    assign ins_new = i_ctl.ins && (i_label != '0) && !hit;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_ctl.clr) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end else if (ins_new) begin
            if (r_count < t_cnt'(MAX_SEL)) begin
                n_count = r_count + t_cnt'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // The new label goes into the first free slot.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_SEL; k++) begin
            if (!i_ctl.clr && ins_new && (r_count == t_cnt'(k))) begin
                r_set[k] <= i_label;
            end
        end
    end

    assign o_stat.hit      = hit;
    assign o_stat.ovf      = r_ovf;
    assign o_stat.count_nz = (r_count != '0);

    `RLSR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= t_cnt'(MAX_SEL), "set count too large")
    `RLSR_ASSERT(a_ovf_full, i_clk, i_rst_n, r_ovf |-> (r_count == t_cnt'(MAX_SEL)), "overflow with room left")
    `RLSR_ASSERT(a_clr_empties, i_clk, i_rst_n, i_ctl.clr |=> ((r_count == '0) && !r_ovf), "set not cleared")

endmodule

// ===== src/region_label_select_relabel.sv =====
// ---------------------------------------------------------------------------
// region_label_select_relabel
// Label image with load, read, rectangle select, set gather, relabel sweep and clear.
// ---------------------------------------------------------------------------
// Per word: load and read touch one pixel; clear sweeps all npix = width *
// height pixels; select scans the clipped rectangle, then sweeps all npix
// pixels (no sweep if no label is found, no scan if the clipped box is empty).
// The rate is set by the single read port of each store: one pixel a cycle.
// A result is staged, then moved to the output register once the last one is taken.
// After reset the mask store is cleared through all 65536 addresses; no command word is
// taken then, configuration writes are.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module region_label_select_relabel (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rlsr_cfg_if.sink      i_cfg,
    rlsr_item_if.sink     i_item,
    rlsr_result_if.source o_result
);
    import rlsr_pkg::*;

    localparam int ST_BITS = 4;
    localparam logic [ST_BITS-1:0] S_INIT   = 4'd0;
    localparam logic [ST_BITS-1:0] S_IDLE   = 4'd1;
    localparam logic [ST_BITS-1:0] S_LOAD   = 4'd2;
    localparam logic [ST_BITS-1:0] S_RD     = 4'd3;
    localparam logic [ST_BITS-1:0] S_RD2    = 4'd4;
    localparam logic [ST_BITS-1:0] S_CLR    = 4'd5;
    localparam logic [ST_BITS-1:0] S_CDRAIN = 4'd6;
    localparam logic [ST_BITS-1:0] S_SPREP  = 4'd7;
    localparam logic [ST_BITS-1:0] S_SMUL   = 4'd8;
    localparam logic [ST_BITS-1:0] S_SADD   = 4'd9;
    localparam logic [ST_BITS-1:0] S_SCAN   = 4'd10;
    localparam logic [ST_BITS-1:0] S_SDRAIN = 4'd11;
    localparam logic [ST_BITS-1:0] S_SDEC   = 4'd12;
    localparam logic [ST_BITS-1:0] S_SWEEP  = 4'd13;
    localparam logic [ST_BITS-1:0] S_WDRAIN = 4'd14;
    localparam logic [ST_BITS-1:0] S_RESULT = 4'd15;

    localparam int MUL_BITS = ROW_BITS + DIM_BITS;

    // Control state
    logic [ST_BITS-1:0] r_state, n_state;
    t_pix   r_p, n_p;
    logic   r_pv, n_pv;
    logic   r_ov, n_ov;
    t_dim   r_w, n_w;
    t_dim   r_h, n_h;
    t_npix  r_npix, n_npix;

    // Payload
    t_pix   r_pd, n_pd;
    t_pix   r_addr, n_addr;
    t_pix   r_colad, n_colad;
    logic [COL_BITS-1:0] r_c, n_c, r_cb, n_cb, r_ce, n_ce;
    logic [ROW_BITS-1:0] r_r, n_r, r_rb, n_rb, r_re, n_re;
    t_pix   r_idx, n_idx;
    logic   r_idx_ok, n_idx_ok;
    t_label r_label, n_label;
    t_coord r_fc, n_fc, r_fr, n_fr, r_lc, n_lc, r_lr, n_lr;
    t_fill  r_fill, n_fill;
    t_fill  r_res_mask, n_res_mask;
    logic   r_res_found, n_res_found;
    logic   r_res_ovf, n_res_ovf;
    t_fill  r_out_mask, n_out_mask;
    logic   r_out_found, n_out_found;
    logic   r_out_ovf, n_out_ovf;

    t_lbl_req  lbl_req;
    t_mask_req mask_req;
    t_set_ctl  set_ctl;
    t_set_stat set_stat;
    t_label    work_rdata;
    t_label    orig_rdata;
    t_fill     mask_rdata;

    t_dim   cfg_dim;
    t_dim   mul_a, mul_b;
    logic [2*DIM_BITS-1:0] cfg_prod;
    logic [MUL_BITS-1:0]   base_prod;
    logic signed [SCOORD_BITS-1:0] s_wm1, s_hm1, s_c0, s_c1, s_r0, s_r1;
    logic   rect_empty;
    logic   item_acc;

    rlsr_label_mem u_label_mem (
        .i_clk        (i_clk),
        .i_req        (lbl_req),
        .o_work_rdata (work_rdata),
        .o_orig_rdata (orig_rdata)
    );

    rlsr_mask_mem u_mask_mem (
        .i_clk   (i_clk),
        .i_req   (mask_req),
        .o_rdata (mask_rdata)
    );

    rlsr_label_set u_label_set (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (set_ctl),
        .i_label (work_rdata),
        .o_stat  (set_stat)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);
    assign item_acc     = i_item.valid && (r_state == S_IDLE);

    assign o_result.valid      = r_ov;
    assign o_result.mask_value = r_out_mask;
    assign o_result.found      = r_out_found;
    assign o_result.overflow   = r_out_ovf;

    // Pixel count is formed when a dimension is written.
    always_comb begin
        if (i_cfg.index == CFG_WIDTH) begin
            cfg_dim = clamp_dim(i_cfg.data, t_dim'(MAX_WIDTH));
            mul_a   = cfg_dim;
            mul_b   = r_h;
        end else begin
            cfg_dim = clamp_dim(i_cfg.data, t_dim'(MAX_HEIGHT));
            mul_a   = r_w;
            mul_b   = cfg_dim;
        end
        cfg_prod = (2*DIM_BITS)'(mul_a) * (2*DIM_BITS)'(mul_b);
    end

    assign base_prod = MUL_BITS'(r_rb) * MUL_BITS'(r_w);

    // Rectangle clipping, signed with one guard bit.
    always_comb begin
        s_wm1 = $signed(SCOORD_BITS'(r_w)) - SCOORD_BITS'(1);
        s_hm1 = $signed(SCOORD_BITS'(r_h)) - SCOORD_BITS'(1);
        s_c0  = (r_fc < 0) ? '0 : SCOORD_BITS'(r_fc);
        s_r0  = (r_fr < 0) ? '0 : SCOORD_BITS'(r_fr);
        s_c1  = (SCOORD_BITS'(r_lc) > s_wm1) ? s_wm1 : SCOORD_BITS'(r_lc);
        s_r1  = (SCOORD_BITS'(r_lr) > s_hm1) ? s_hm1 : SCOORD_BITS'(r_lr);
        rect_empty = (s_c0 > s_c1) || (s_r0 > s_r1);
    end

    // Memory and set control
    always_comb begin
        lbl_req            = '0;
        lbl_req.waddr      = r_pd;
        lbl_req.work_raddr = r_addr;
        lbl_req.orig_raddr = r_p;
        mask_req           = '0;
        mask_req.waddr     = r_p;
        mask_req.raddr     = r_idx;
        set_ctl.clr        = (r_state == S_SPREP);
        set_ctl.ins        = r_pv && ((r_state == S_SCAN) || (r_state == S_SDRAIN));

        case (r_state)
            S_INIT: begin
                mask_req.we = 1'b1;
            end
            S_LOAD: begin
                if (r_idx_ok) begin
                    lbl_req.work_we = 1'b1;
                    lbl_req.orig_we = 1'b1;
                    lbl_req.waddr   = r_idx;
                    lbl_req.wdata   = r_label;
                    mask_req.we     = 1'b1;
                    mask_req.waddr  = r_idx;
                end
            end
            S_CLR: begin
                mask_req.we = 1'b1;
            end
            S_SWEEP: begin
                lbl_req.work_raddr = r_p;
            end
            default: begin
            end
        endcase

        // Copy back the original label in the cycle after its read.
        if (r_pv && ((r_state == S_CLR) || (r_state == S_CDRAIN))) begin
            lbl_req.work_we = 1'b1;
            lbl_req.wdata   = orig_rdata;
        end

        // Relabel a selected pixel in the cycle after its read.
        if (r_pv && set_stat.hit && ((r_state == S_SWEEP) || (r_state == S_WDRAIN))) begin
            lbl_req.work_we = 1'b1;
            lbl_req.wdata   = '0;
            mask_req.we     = 1'b1;
            mask_req.waddr  = r_pd;
            mask_req.wdata  = r_fill;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_pv    = 1'b0;
        n_ov    = r_ov;
        n_w     = r_w;
        n_h     = r_h;
        n_npix  = r_npix;
        n_pd    = r_p;
        n_addr  = r_addr;
        n_colad = r_colad;
        n_c     = r_c;
        n_r     = r_r;
        n_cb    = r_cb;
        n_ce    = r_ce;
        n_rb    = r_rb;
        n_re    = r_re;
        n_idx   = r_idx;
        n_idx_ok = r_idx_ok;
        n_label = r_label;
        n_fc    = r_fc;
        n_fr    = r_fr;
        n_lc    = r_lc;
        n_lr    = r_lr;
        n_fill  = r_fill;
        n_res_mask  = r_res_mask;
        n_res_found = r_res_found;
        n_res_ovf   = r_res_ovf;
        n_out_mask  = r_out_mask;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;

        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_WIDTH) begin
                n_w = cfg_dim;
            end else begin
                n_h = cfg_dim;
            end
            n_npix = cfg_prod[NPIX_BITS-1:0];
        end

        if (r_ov && o_result.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                n_p = r_p + t_pix'(1);
                if (r_p == t_pix'(PIXELS - 1)) begin
                    n_p     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (item_acc) begin
                    n_idx    = i_item.pixel_index[PIX_BITS-1:0];
                    n_idx_ok = (NPIX_BITS'(i_item.pixel_index) < r_npix);
                    n_label  = i_item.label_value[LABEL_BITS-1:0];
                    n_fc     = i_item.first_column;
                    n_fr     = i_item.first_row;
                    n_lc     = i_item.last_column;
                    n_lr     = i_item.last_row;
                    n_fill   = i_item.fill_value;
                    n_p      = '0;
                    unique case (i_item.command)
                        CMD_LOAD:   n_state = S_LOAD;
                        CMD_SELECT: n_state = S_SPREP;
                        CMD_CLEAR:  n_state = S_CLR;
                        CMD_READ:   n_state = S_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                n_res_mask  = '0;
                n_res_found = 1'b1;
                n_res_ovf   = 1'b0;
                n_state     = S_RESULT;
            end
            S_RD: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_res_mask  = r_idx_ok ? mask_rdata : '0;
                n_res_found = 1'b1;
                n_res_ovf   = 1'b0;
                n_state     = S_RESULT;
            end
            S_CLR: begin
                n_pv = 1'b1;
                n_p  = r_p + t_pix'(1);
                if (NPIX_BITS'(r_p) == r_npix - t_npix'(1)) begin
                    n_state = S_CDRAIN;
                end
            end
            S_CDRAIN: begin
                n_res_mask  = '0;
                n_res_found = 1'b1;
                n_res_ovf   = 1'b0;
                n_state     = S_RESULT;
            end
            S_SPREP: begin
                n_cb = s_c0[COL_BITS-1:0];
                n_ce = s_c1[COL_BITS-1:0];
                n_rb = s_r0[ROW_BITS-1:0];
                n_re = s_r1[ROW_BITS-1:0];
                if (rect_empty) begin
                    n_res_mask  = '0;
                    n_res_found = 1'b0;
                    n_res_ovf   = 1'b0;
                    n_state     = S_RESULT;
                end else begin
                    n_state = S_SMUL;
                end
            end
            S_SMUL: begin
                n_colad = base_prod[PIX_BITS-1:0];
                n_state = S_SADD;
            end
            S_SADD: begin
                n_colad = r_colad + t_pix'(r_cb);
                n_addr  = r_colad + t_pix'(r_cb);
                n_c     = r_cb;
                n_r     = r_rb;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Columns outer, rows inner: a row step adds the width.
                n_pv = 1'b1;
                if (r_r == r_re) begin
                    if (r_c == r_ce) begin
                        n_state = S_SDRAIN;
                    end else begin
                        n_c     = r_c + COL_BITS'(1);
                        n_r     = r_rb;
                        n_colad = r_colad + t_pix'(1);
                        n_addr  = r_colad + t_pix'(1);
                    end
                end else begin
                    n_r    = r_r + ROW_BITS'(1);
                    n_addr = r_addr + t_pix'(r_w);
                end
            end
            S_SDRAIN: begin
                n_state = S_SDEC;
            end
            S_SDEC: begin
                n_p = '0;
                if (!set_stat.count_nz) begin
                    n_res_mask  = '0;
                    n_res_found = 1'b0;
                    n_res_ovf   = 1'b0;
                    n_state     = S_RESULT;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_pv = 1'b1;
                n_p  = r_p + t_pix'(1);
                if (NPIX_BITS'(r_p) == r_npix - t_npix'(1)) begin
                    n_state = S_WDRAIN;
                end
            end
            S_WDRAIN: begin
                n_res_mask  = '0;
                n_res_found = 1'b1;
                n_res_ovf   = set_stat.ovf;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (!r_ov || o_result.ready) begin
                    n_ov        = 1'b1;
                    n_out_mask  = r_res_mask;
                    n_out_found = r_res_found;
                    n_out_ovf   = r_res_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_p     <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_w     <= DIM_RESET;
            r_h     <= DIM_RESET;
            r_npix  <= t_npix'(PIXELS);
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_w     <= n_w;
            r_h     <= n_h;
            r_npix  <= n_npix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pd        <= n_pd;
        r_addr      <= n_addr;
        r_colad     <= n_colad;
        r_c         <= n_c;
        r_r         <= n_r;
        r_cb        <= n_cb;
        r_ce        <= n_ce;
        r_rb        <= n_rb;
        r_re        <= n_re;
        r_idx       <= n_idx;
        r_idx_ok    <= n_idx_ok;
        r_label     <= n_label;
        r_fc        <= n_fc;
        r_fr        <= n_fr;
        r_lc        <= n_lc;
        r_lr        <= n_lr;
        r_fill      <= n_fill;
        r_res_mask  <= n_res_mask;
        r_res_found <= n_res_found;
        r_res_ovf   <= n_res_ovf;
        r_out_mask  <= n_out_mask;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
    end

    `RLSR_ASSERT(a_sweep_has_set, i_clk, i_rst_n,
        (r_state == S_SWEEP) |-> set_stat.count_nz, "sweep with empty set")
    `RLSR_ASSERT(a_drain_pending, i_clk, i_rst_n,
        ((r_state == S_SDRAIN) || (r_state == S_WDRAIN) || (r_state == S_CDRAIN)) |-> r_pv,
        "drain without a read in flight")
    `RLSR_ASSERT(a_result_waits, i_clk, i_rst_n,
        ((r_state == S_RESULT) && r_ov && !o_result.ready) |=> (r_state == S_RESULT),
        "result register overwritten")
    `RLSR_ASSERT(a_sweep_in_image, i_clk, i_rst_n,
        ((r_state == S_SWEEP) || (r_state == S_CLR)) |-> (NPIX_BITS'(r_p) < r_npix),
        "sweep address outside image")

endmodule
